FILE: sv/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Both expect a signal named clk in the calling scope; SAD_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define SAD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/sad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sad_pkg
// Shared constants, codes, types and the padding function of the stack
// allocator.
// ----------------------------------------------------------------------------
package sad_pkg;

    localparam int MAX_BLOCKS   = 16;
    localparam int HEADER_BYTES = 4;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W       = 32;
    localparam int USED_W       = 25;
    localparam int SIZE_W       = 24;
    localparam int PAD_W        = 9;
    localparam int REL_W        = 5;
    localparam int CFG_IDX_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_NULL       = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_CHECK,
        S_FSTART,
        S_RD,
        S_CMP,
        S_POP_RD,
        S_POP
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    ld_pad;
        logic    commit;
        logic    scan_init;
        logic    scan_dec;
        logic    set_defer;
        logic    rd_top;
        logic    pop;
        logic    set_status;
        status_t status;
    } sad_cmd_t;

    typedef struct packed {
        logic opcode;
        logic addr_null;
        logic top_zero;
        logic size_zero;
        logic fits;
        logic full;
        logic match;
        logic match_deferred;
        logic idx_is_top;
        logic idx_zero;
        logic more_pop;
    } sad_sts_t;

    function automatic logic [PAD_W-1:0] pad_bytes(input logic [6:0] low,
                                                   input logic [2:0] lg);
        logic [7:0]       a;
        logic [7:0]       m;
        logic [PAD_W-1:0] adj;
        logic [PAD_W-1:0] need;
        a    = 8'd1 << lg;
        m    = a - 8'd1;
        adj  = PAD_W'((a - {1'b0, low}) & m);
        need = '0;
        if (adj < PAD_W'(HEADER_BYTES))
        begin
            need = PAD_W'(HEADER_BYTES) - adj;
            adj  = adj + (((need + PAD_W'(m)) >> lg) << lg);
        end
        return adj;
    endfunction

endpackage
`default_nettype wire

FILE: sv/sad_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/sad_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sad_ctrl
// Sequencer: steps allocate, search and pop cascade, and owns the handshakes.
// ----------------------------------------------------------------------------
module sad_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire sad_pkg::sad_sts_t sts,
    output sad_pkg::sad_cmd_t     cmd
);

    sad_pkg::state_t state_reg;
    sad_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sad_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == sad_pkg::S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.status     = sad_pkg::ST_OK;
        case (state_reg)
            sad_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    state_next = sad_pkg::S_FSTART;
                end
            end
            sad_pkg::S_FSTART:
            begin
                if (!sts.opcode)
                begin
                    cmd.ld_pad = 1'b1;
                    state_next = sad_pkg::S_PAD;
                end
                else if (sts.addr_null)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sad_pkg::ST_NULL;
                    out_valid_next = 1'b1;
                    state_next     = sad_pkg::S_IDLE;
                end
                else if (sts.top_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sad_pkg::ST_UNKNOWN;
                    out_valid_next = 1'b1;
                    state_next     = sad_pkg::S_IDLE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = sad_pkg::S_RD;
                end
            end
            sad_pkg::S_PAD:
            begin
                state_next = sad_pkg::S_CHECK;
            end
            sad_pkg::S_CHECK:
            begin
                out_valid_next = 1'b1;
                state_next     = sad_pkg::S_IDLE;
                cmd.set_status = 1'b1;
                if (sts.size_zero)
                begin
                    cmd.status = sad_pkg::ST_ZERO_SIZE;
                end
                else if (!sts.fits)
                begin
                    cmd.status = sad_pkg::ST_NO_SPACE;
                end
                else if (sts.full)
                begin
                    cmd.status = sad_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    cmd.commit = 1'b1;
                end
            end
            sad_pkg::S_RD:
            begin
                state_next = sad_pkg::S_CMP;
            end
            sad_pkg::S_CMP:
            begin
                if (sts.match)
                begin
                    if (sts.match_deferred)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = sad_pkg::ST_UNKNOWN;
                        out_valid_next = 1'b1;
                        state_next     = sad_pkg::S_IDLE;
                    end
                    else if (sts.idx_is_top)
                    begin
                        cmd.rd_top = 1'b1;
                        state_next = sad_pkg::S_POP_RD;
                    end
                    else
                    begin
                        cmd.set_defer  = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = sad_pkg::S_IDLE;
                    end
                end
                else if (sts.idx_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sad_pkg::ST_UNKNOWN;
                    out_valid_next = 1'b1;
                    state_next     = sad_pkg::S_IDLE;
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                    state_next   = sad_pkg::S_RD;
                end
            end
            sad_pkg::S_POP_RD:
            begin
                cmd.rd_top = 1'b1;
                state_next = sad_pkg::S_POP;
            end
            sad_pkg::S_POP:
            begin
                cmd.pop = 1'b1;
                if (sts.more_pop)
                begin
                    state_next = sad_pkg::S_POP_RD;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = sad_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sad_pkg::S_IDLE;
            end
        endcase
    end

    `SAD_ASSERT_ALWAYS(a_ready_excl, !(in_ready && out_valid), "accept while result held")
    `SAD_ASSERT(a_busy_after_accept, cmd.accept |=> !in_ready && !out_valid,
                "second transfer taken during work")
    `SAD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")

endmodule
`default_nettype wire

FILE: sv/sad_dp.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sad_dp
// Datapath: configuration, pool counters, issued-block stores, deferred flags
// and the result registers.
// ----------------------------------------------------------------------------
module sad_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [sad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              opcode,
    input  wire logic [sad_pkg::SIZE_W-1:0]        alloc_size,
    input  wire logic [2:0]                        align_log2,
    input  wire logic [sad_pkg::ADDR_W-1:0]        free_address,
    input  wire sad_pkg::sad_cmd_t                 cmd,
    output sad_pkg::sad_sts_t                      sts,
    output logic      [sad_pkg::ADDR_W-1:0]        address,
    output logic      [2:0]                        status,
    output logic      [sad_pkg::REL_W-1:0]         released_count,
    output logic      [sad_pkg::USED_W-1:0]        used_bytes
);

    localparam int IW = sad_pkg::IDX_W;
    localparam int CW = sad_pkg::CNT_W;

    logic [31:0]                    base_reg;
    logic [sad_pkg::USED_W-1:0]     bytes_reg;
    logic [CW-1:0]                  top_reg;
    logic [sad_pkg::USED_W-1:0]     used_reg;
    logic [sad_pkg::MAX_BLOCKS-1:0] defer_reg;
    logic [IW-1:0]                  idx_reg;
    logic                           op_reg;
    logic [sad_pkg::SIZE_W-1:0]     size_reg;
    logic [2:0]                     lg_reg;
    logic [sad_pkg::ADDR_W-1:0]     faddr_reg;
    logic [31:0]                    bu_reg;
    logic [sad_pkg::PAD_W-1:0]      adj_reg;
    logic [sad_pkg::ADDR_W-1:0]     addr_reg;
    sad_pkg::status_t               status_reg;
    logic [sad_pkg::REL_W-1:0]      rel_reg;

    logic [CW-1:0]                  top_m1;
    logic [CW-1:0]                  top_m2;
    logic [31:0]                    bu_next;
    logic [sad_pkg::USED_W:0]       need;
    logic [31:0]                    new_addr;
    logic [IW-1:0]                  raddr;
    logic [31:0]                    stack_rdata;
    logic [sad_pkg::USED_W-1:0]     mark_rdata;

    assign top_m1   = top_reg - CW'(1);
    assign top_m2   = top_reg - CW'(2);
    assign bu_next  = base_reg + 32'(used_reg);
    assign need     = (sad_pkg::USED_W+1)'(used_reg) + (sad_pkg::USED_W+1)'(size_reg)
                    + (sad_pkg::USED_W+1)'(adj_reg);
    assign new_addr = bu_reg + 32'(adj_reg);
    assign raddr    = cmd.rd_top ? top_m1[IW-1:0] : idx_reg;

    sad_ram #(.WIDTH(32), .DEPTH(sad_pkg::MAX_BLOCKS)) u_stack (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (top_reg[IW-1:0]),
        .wdata (new_addr),
        .raddr (raddr),
        .rdata (stack_rdata)
    );

    sad_ram #(.WIDTH(sad_pkg::USED_W), .DEPTH(sad_pkg::MAX_BLOCKS)) u_mark (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (top_reg[IW-1:0]),
        .wdata (used_reg),
        .raddr (raddr),
        .rdata (mark_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            bytes_reg  <= '0;
            top_reg    <= '0;
            used_reg   <= '0;
            defer_reg  <= '0;
            status_reg <= sad_pkg::ST_OK;
            rel_reg    <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == sad_pkg::CFG_POOL_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else if (cfg_index == sad_pkg::CFG_POOL_BYTES)
                begin
                    bytes_reg <= cfg_data[sad_pkg::USED_W-1:0];
                end
            end
            if (cmd.accept)
            begin
                status_reg <= sad_pkg::ST_OK;
                rel_reg    <= '0;
                addr_reg   <= '0;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            if (cmd.commit)
            begin
                addr_reg                     <= new_addr;
                defer_reg[top_reg[IW-1:0]]   <= 1'b0;
                top_reg                      <= top_reg + CW'(1);
                used_reg                     <= need[sad_pkg::USED_W-1:0];
            end
            if (cmd.set_defer)
            begin
                defer_reg[idx_reg] <= 1'b1;
            end
            if (cmd.pop)
            begin
                top_reg                    <= top_m1;
                used_reg                   <= mark_rdata;
                defer_reg[top_m1[IW-1:0]]  <= 1'b0;
                if (rel_reg != '1)
                begin
                    rel_reg <= rel_reg + sad_pkg::REL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= opcode;
            size_reg  <= alloc_size;
            lg_reg    <= align_log2;
            faddr_reg <= free_address;
        end
        if (cmd.ld_pad)
        begin
            bu_reg  <= bu_next;
            adj_reg <= sad_pkg::pad_bytes(bu_next[6:0], lg_reg);
        end
        if (cmd.scan_init)
        begin
            idx_reg <= top_m1[IW-1:0];
        end
        else if (cmd.scan_dec)
        begin
            idx_reg <= idx_reg - IW'(1);
        end
    end

    always_comb
    begin
        sts                = '0;
        sts.opcode         = op_reg;
        sts.addr_null      = (faddr_reg == '0);
        sts.top_zero       = (top_reg == '0);
        sts.size_zero      = (size_reg == '0);
        sts.fits           = (need <= (sad_pkg::USED_W+1)'(bytes_reg));
        sts.full           = (top_reg == CW'(sad_pkg::MAX_BLOCKS));
        sts.match          = (stack_rdata == faddr_reg);
        sts.match_deferred = defer_reg[idx_reg];
        sts.idx_is_top     = (idx_reg == top_m1[IW-1:0]);
        sts.idx_zero       = (idx_reg == '0);
        sts.more_pop       = (top_reg > CW'(1)) && defer_reg[top_m2[IW-1:0]];
    end

    assign address        = addr_reg;
    assign status         = status_reg;
    assign released_count = rel_reg;
    assign used_bytes     = used_reg;

    `SAD_ASSERT(a_top_range, top_reg <= CW'(sad_pkg::MAX_BLOCKS), "stack depth overrun")
    `SAD_ASSERT(a_pop_nonempty, cmd.pop |-> top_reg != '0, "pop of empty stack")
    `SAD_ASSERT(a_defer_not_top, cmd.set_defer |-> idx_reg != top_m1[IW-1:0],
                "top block marked deferred")

endmodule
`default_nettype wire

FILE: sv/stack_allocator_deferred_free_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_allocator_deferred_free_core
// Stack allocator over one pool with aligned blocks and deferred frees.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes pool_base (index 0) and pool_bytes (index 1); it is
//   always ready and should only be used while the block is idle.
//   in channel takes one request (allocate or free) per transfer; out channel
//   returns one result per request.
//   Allocate: a start step, padding, then the fit check and result.
//   Free: a start step, a read and a compare per stack entry searched from
//   the top, then a read and a pop per block popped in the cascade; the
//   stack RAM read port sets this split into read and compare or pop steps.
//   One request is in flight at a time; in_ready is low until the result has
//   been taken, so a stalled receiver holds the result and blocks input.
//   Reset empties the stack, clears the deferred flags, used count and both
//   registers; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module stack_allocator_deferred_free_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          opcode,
    input  wire logic [23:0]                   alloc_size,
    input  wire logic [2:0]                    align_log2,
    input  wire logic [31:0]                   free_address,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [31:0]                   address,
    output logic      [2:0]                    status,
    output logic      [4:0]                    released_count,
    output logic      [24:0]                   used_bytes
);

    sad_pkg::sad_cmd_t cmd;
    sad_pkg::sad_sts_t sts;

    assign cfg_ready = 1'b1;

    sad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sad_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .alloc_size     (alloc_size),
        .align_log2     (align_log2),
        .free_address   (free_address),
        .cmd            (cmd),
        .sts            (sts),
        .address        (address),
        .status         (status),
        .released_count (released_count),
        .used_bytes     (used_bytes)
    );

endmodule
`default_nettype wire

FILE: tb/stack_allocator_deferred_free_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_allocator_deferred_free_core_test
// Drives allocate and free requests through the stack allocator, predicts
// every result with an independent allocator model and checks each result
// field by field, across several pool settings and idling patterns.
// ----------------------------------------------------------------------------

class alloc_scoreboard;
    typedef struct packed {
        logic [31:0] address;
        logic [2:0]  status;
        logic [4:0]  released_count;
        logic [24:0] used_bytes;
    } alloc_result_t;

    logic [31:0] base;
    logic [24:0] pool_size;
    logic [31:0] block_addr [sad_pkg::MAX_BLOCKS];
    logic [24:0] mark [sad_pkg::MAX_BLOCKS];
    bit          deferred [sad_pkg::MAX_BLOCKS];
    int          depth;
    logic [24:0] used;
    alloc_result_t pending [$];
    int          errors;

    function void clear();
        base = '0;
        pool_size = '0;
        depth = 0;
        used = '0;
        errors = 0;
        foreach (deferred[i])
            deferred[i] = 0;
        pending.delete();
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
        if (idx == sad_pkg::CFG_POOL_BASE)
            base = data;
        else if (idx == sad_pkg::CFG_POOL_BYTES)
            pool_size = data[24:0];
    endfunction

    function longint padding(longint top, int lg);
        longint a;
        longint adj;
        longint need;
        a = longint'(1) << lg;
        adj = (a - (top & (a - 1))) & (a - 1);
        if (adj < sad_pkg::HEADER_BYTES)
        begin
            need = sad_pkg::HEADER_BYTES - adj;
            adj += ((need + a - 1) / a) * a;
        end
        return adj;
    endfunction

    function void pop_block();
        depth--;
        used = mark[depth];
        deferred[depth] = 0;
    endfunction

    function void note_request(logic op, logic [23:0] size, logic [2:0] lg,
                               logic [31:0] faddr);
        alloc_result_t r;
        longint top;
        longint adj;
        int idx;
        r = '0;
        r.status = sad_pkg::ST_OK;
        if (op == 1'b0)
        begin
            if (size == 0)
                r.status = sad_pkg::ST_ZERO_SIZE;
            else
            begin
                top = longint'(base) + used;
                adj = padding(top, lg);
                if (longint'(used) + size + adj > pool_size)
                    r.status = sad_pkg::ST_NO_SPACE;
                else if (depth >= sad_pkg::MAX_BLOCKS)
                    r.status = sad_pkg::ST_TABLE_FULL;
                else
                begin
                    r.address = 32'(top + adj);
                    block_addr[depth] = r.address;
                    mark[depth] = used;
                    deferred[depth] = 0;
                    depth++;
                    used = 25'(longint'(used) + size + adj);
                end
            end
        end
        else if (faddr == 0)
            r.status = sad_pkg::ST_NULL;
        else
        begin
            idx = -1;
            for (int i = depth - 1; i >= 0; i--)
                if (idx < 0 && block_addr[i] == faddr)
                    idx = i;
            if (idx < 0 || deferred[idx])
                r.status = sad_pkg::ST_UNKNOWN;
            else if (idx == depth - 1)
            begin
                pop_block();
                r.released_count = 1;
                while (depth > 0 && deferred[depth-1])
                begin
                    pop_block();
                    r.released_count++;
                end
            end
            else
                deferred[idx] = 1;
        end
        r.used_bytes = used;
        pending = {pending, r};
    endfunction

    function void check_result(logic [31:0] a, logic [2:0] s, logic [4:0] rc,
                               logic [24:0] u);
        alloc_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result address=%h status=%0d", a, s);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a !== e.address)
        begin
            $error("address expected %h actual %h", e.address, a);
            errors++;
        end
        if (s !== e.status)
        begin
            $error("status expected %0d actual %0d", e.status, s);
            errors++;
        end
        if (rc !== e.released_count)
        begin
            $error("released_count expected %0d actual %0d", e.released_count, rc);
            errors++;
        end
        if (u !== e.used_bytes)
        begin
            $error("used_bytes expected %0d actual %0d", e.used_bytes, u);
            errors++;
        end
    endfunction
endclass

module stack_allocator_deferred_free_core_test;
    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [23:0] alloc_size;
    logic [2:0]  align_log2;
    logic [31:0] free_address;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] address;
    logic [2:0]  status;
    logic [4:0]  released_count;
    logic [24:0] used_bytes;

    alloc_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    logic [31:0] live_addrs [$];

    stack_allocator_deferred_free_core u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(address, status, released_count, used_bytes);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[stack_allocator_deferred_free_core] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input logic op, input logic [23:0] size,
                                input logic [2:0] lg, input logic [31:0] faddr);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        alloc_size   <= size;
        align_log2   <= lg;
        free_address <= faddr;
        do @(posedge clk); while (!in_ready);
        sb.note_request(op, size, lg, faddr);
        if (op == 1'b0 && sb.pending[$].status == sad_pkg::ST_OK)
            live_addrs = {live_addrs, sb.pending[$].address};
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic random_requests(input int n);
        int pick;
        logic [31:0] fa;
        logic [23:0] sz;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                sz = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200));
                if ($urandom_range(29) == 0)
                    sz = 0;
                send_request(1'b0, sz, 3'($urandom), 32'($urandom));
            end
            else
            begin
                if (pick < 90 && live_addrs.size() != 0)
                    fa = live_addrs[$urandom_range(live_addrs.size() - 1)];
                else if (pick < 94)
                    fa = 0;
                else
                    fa = $urandom;
                send_request(1'b1, 24'($urandom), 3'($urandom), fa);
            end
            if (live_addrs.size() > 64)
                live_addrs.delete(0);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        send_idle_pct = 13;
        recv_idle_pct = 56;
        quiet_cycles  = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = 1'b0;
        alloc_size = '0;
        align_log2 = '0;
        free_address = '0;
        out_ready = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty pool, then a small pool with every case
        send_request(1'b0, 24'd1, 3'd0, 32'd0);
        drain();
        write_reg(sad_pkg::CFG_POOL_BASE, 32'hFFFF_FFF0);
        write_reg(sad_pkg::CFG_POOL_BYTES, 32'd4096);
        write_reg(8'd7, 32'hDEAD_BEEF);
        send_request(1'b0, 24'd0, 3'd0, 32'd0);
        send_request(1'b0, 24'hFF_FFFF, 3'd7, 32'hFFFF_FFFF);
        send_request(1'b0, 24'd16, 3'd7, 32'd0);
        send_request(1'b0, 24'd1, 3'd0, 32'd0);
        send_request(1'b0, 24'd3, 3'd2, 32'd0);
        send_request(1'b0, 24'd5, 3'd3, 32'd0);
        send_request(1'b1, 24'd0, 3'd0, 32'd0);
        send_request(1'b1, 24'd0, 3'd0, 32'h1234_5678);
        send_request(1'b1, 24'd0, 3'd0, live_addrs[1]);
        send_request(1'b1, 24'd0, 3'd0, live_addrs[1]);
        send_request(1'b1, 24'd0, 3'd0, live_addrs[2]);
        send_request(1'b1, 24'd0, 3'd0, live_addrs[3]);
        for (int k = 0; k < 17; k++)
            send_request(1'b0, 24'd8, 3'($urandom), 32'd0);
        drain();
        live_addrs.delete();

        write_reg(sad_pkg::CFG_POOL_BASE, 32'h0000_1000);
        write_reg(sad_pkg::CFG_POOL_BYTES, 32'd16777216);
        random_requests(300);
        drain();
        write_reg(sad_pkg::CFG_POOL_BASE, 32'($urandom));
        write_reg(sad_pkg::CFG_POOL_BYTES, 32'd600);
        random_requests(150);
        drain();

        send_idle_pct = 56;
        recv_idle_pct = 13;
        write_reg(sad_pkg::CFG_POOL_BASE, 32'd0);
        write_reg(sad_pkg::CFG_POOL_BYTES, 32'd2000);
        random_requests(350);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(sad_pkg::CFG_POOL_BASE, 32'hFFFF_FF00);
        write_reg(sad_pkg::CFG_POOL_BYTES, 32'd1500);
        random_requests(420);
        drain();

        if (sb.errors == 0)
            $display("[stack_allocator_deferred_free_core] OK");
        else
            $display("[stack_allocator_deferred_free_core] ERROR");
        $finish;
    end
endmodule
